[rtl/core/quaternion_vector_rotate_assert.svh]
// Assertion macros for the quaternion rotation RTL.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define QVR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/core/qvr_pkg.sv]
// Types and constants for the quaternion vector rotation block.
// Used by qvr_cfg and quaternion_vector_rotate; depends on nothing.
`timescale 1ns / 1ps

package qvr_pkg;

    // Component width of quaternion, input and result fields
    localparam int COMP_WIDTH = 16;
    // Config address width: four 32-bit registers
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] qx;
        logic signed [COMP_WIDTH-1:0] qy;
        logic signed [COMP_WIDTH-1:0] qz;
        logic signed [COMP_WIDTH-1:0] qw;
    } t_quat;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] vec_x;
        logic signed [COMP_WIDTH-1:0] vec_y;
        logic signed [COMP_WIDTH-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] out_x;
        logic signed [COMP_WIDTH-1:0] out_y;
        logic signed [COMP_WIDTH-1:0] out_z;
        logic                         saturated;
    } t_vec_out;

endpackage

[rtl/core/qvr_cfg.sv]
// APB register file holding the rotation quaternion.
// Depends on qvr_pkg for the register map and the quaternion type.
`timescale 1ns / 1ps

module qvr_cfg #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0]    paddr,
    input  logic [qvr_pkg::DATA_W-1:0]    pwdata,
    output logic [qvr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output qvr_pkg::t_quat                o_quat
);

    localparam int CW = qvr_pkg::COMP_WIDTH;
    // Scalar part resets to 1.0 (identity rotation)
    localparam logic [CW-1:0] QW_RESET = CW'(64'd1 << FRAC_BITS);

    qvr_pkg::t_quat           r_quat;
    qvr_pkg::t_reg_idx        w_idx;
    logic signed [CW-1:0]     w_rd_sel;

    assign w_idx  = qvr_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_quat = r_quat;

    // Write on the access phase of a write beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.qx <= '0;
            r_quat.qy <= '0;
            r_quat.qz <= '0;
            r_quat.qw <= QW_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                qvr_pkg::REG_QUAT_X: r_quat.qx <= pwdata[CW-1:0];
                qvr_pkg::REG_QUAT_Y: r_quat.qy <= pwdata[CW-1:0];
                qvr_pkg::REG_QUAT_Z: r_quat.qz <= pwdata[CW-1:0];
                qvr_pkg::REG_QUAT_W: r_quat.qw <= pwdata[CW-1:0];
                default:             r_quat    <= r_quat;
            endcase
        end
    end

    // Read back, sign-extended to the bus
    always_comb begin
        unique case (w_idx)
            qvr_pkg::REG_QUAT_X: w_rd_sel = r_quat.qx;
            qvr_pkg::REG_QUAT_Y: w_rd_sel = r_quat.qy;
            qvr_pkg::REG_QUAT_Z: w_rd_sel = r_quat.qz;
            qvr_pkg::REG_QUAT_W: w_rd_sel = r_quat.qw;
            default:             w_rd_sel = '0;
        endcase
    end

    assign prdata = qvr_pkg::DATA_W'(w_rd_sel);

endmodule

[rtl/core/quaternion_vector_rotate.sv]
// Quaternion vector rotation: each beat on the input carries a signed 3-D vector,
// and each result beat carries q * v * conj(q) for the quaternion q in the four
// config registers (signed Q2.FRAC_BITS, reset to identity). Results are scaled
// back by 2*FRAC_BITS with round-half-up and saturated; the saturated flag is set
// when any component clipped. One vector per clock is accepted while o_in_stall is
// low, through the five-stage multiply, sum, multiply, sum, round pipeline, and
// a stalled result only holds the stages behind it that are full. The quaternion
// is read straight from the registers, so write it only while the pipe is empty.
// Depends on qvr_pkg, qvr_cfg and quaternion_vector_rotate_assert.svh.
`timescale 1ns / 1ps

module quaternion_vector_rotate #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0]    paddr,
    input  logic [qvr_pkg::DATA_W-1:0]    pwdata,
    output logic [qvr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Vector input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  qvr_pkg::t_vec_in              i_in_data,
    // Rotated output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output qvr_pkg::t_vec_out             o_out_data
);

    localparam int CW    = qvr_pkg::COMP_WIDTH;
    localparam int NSTG  = 5;
    localparam int P1_W  = 2 * CW;
    localparam int T_W   = (P1_W + 2 > 64) ? 64 : P1_W + 2;
    localparam int P2_W  = (T_W + CW > 64) ? 64 : T_W + CW;
    localparam int R_W   = (P2_W + 2 > 64) ? 64 : P2_W + 2;
    localparam int SHIFT = 2 * FRAC_BITS;

    localparam logic signed [63:0] RND    = 64'sd1 <<< (SHIFT - 1);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic [CW-1:0]      QW_RESET = CW'(64'd1 << FRAC_BITS);

    qvr_pkg::t_quat w_quat;

    qvr_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_quat  (w_quat)
    );

    // Pipeline control: one valid bit per stage, a stage loads when it is
    // empty or the stage after it moves.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_vld[NSTG-1];

    // Stage 1: the twelve products of q and v
    logic signed [P1_W-1:0] r_p1 [12];
    logic signed [P1_W-1:0] n_p1 [12];

    always_comb begin
        n_p1[0]  = P1_W'(w_quat.qw * i_in_data.vec_x);
        n_p1[1]  = P1_W'(w_quat.qy * i_in_data.vec_z);
        n_p1[2]  = P1_W'(w_quat.qz * i_in_data.vec_y);
        n_p1[3]  = P1_W'(w_quat.qw * i_in_data.vec_y);
        n_p1[4]  = P1_W'(w_quat.qz * i_in_data.vec_x);
        n_p1[5]  = P1_W'(w_quat.qx * i_in_data.vec_z);
        n_p1[6]  = P1_W'(w_quat.qw * i_in_data.vec_z);
        n_p1[7]  = P1_W'(w_quat.qx * i_in_data.vec_y);
        n_p1[8]  = P1_W'(w_quat.qy * i_in_data.vec_x);
        n_p1[9]  = P1_W'(w_quat.qx * i_in_data.vec_x);
        n_p1[10] = P1_W'(w_quat.qy * i_in_data.vec_y);
        n_p1[11] = P1_W'(w_quat.qz * i_in_data.vec_z);
    end

    // Stage 2: t = q * v, in order x, y, z, then the negated scalar w
    logic signed [T_W-1:0] r_t [4];
    logic signed [T_W-1:0] n_t [4];

    always_comb begin
        n_t[0] = T_W'(r_p1[0]) + T_W'(r_p1[1])  - T_W'(r_p1[2]);
        n_t[1] = T_W'(r_p1[3]) + T_W'(r_p1[4])  - T_W'(r_p1[5]);
        n_t[2] = T_W'(r_p1[6]) + T_W'(r_p1[7])  - T_W'(r_p1[8]);
        n_t[3] = T_W'(r_p1[9]) + T_W'(r_p1[10]) + T_W'(r_p1[11]);
    end

    // Stage 3: the twelve products of t and q
    logic signed [P2_W-1:0] r_p2 [12];
    logic signed [P2_W-1:0] n_p2 [12];

    always_comb begin
        n_p2[0]  = P2_W'(r_t[3] * w_quat.qx);
        n_p2[1]  = P2_W'(r_t[0] * w_quat.qw);
        n_p2[2]  = P2_W'(r_t[1] * w_quat.qz);
        n_p2[3]  = P2_W'(r_t[2] * w_quat.qy);
        n_p2[4]  = P2_W'(r_t[3] * w_quat.qy);
        n_p2[5]  = P2_W'(r_t[1] * w_quat.qw);
        n_p2[6]  = P2_W'(r_t[2] * w_quat.qx);
        n_p2[7]  = P2_W'(r_t[0] * w_quat.qz);
        n_p2[8]  = P2_W'(r_t[3] * w_quat.qz);
        n_p2[9]  = P2_W'(r_t[2] * w_quat.qw);
        n_p2[10] = P2_W'(r_t[0] * w_quat.qy);
        n_p2[11] = P2_W'(r_t[1] * w_quat.qx);
    end

    // Stage 4: vector part of t * conj(q)
    logic signed [R_W-1:0] r_r [3];
    logic signed [R_W-1:0] n_r [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_r[c] = R_W'(r_p2[4*c])     + R_W'(r_p2[4*c + 1])
                   - R_W'(r_p2[4*c + 2]) + R_W'(r_p2[4*c + 3]);
        end
    end

    // Stage 5: round half up, scale back, saturate
    logic signed [63:0]    w_rnd [3];
    logic signed [63:0]    w_scl [3];
    logic signed [CW-1:0]  w_val [3];
    logic [2:0]            w_clip;
    qvr_pkg::t_vec_out     n_out;
    qvr_pkg::t_vec_out     r_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rnd[c] = 64'(r_r[c]) + RND;
            w_scl[c] = w_rnd[c] >>> SHIFT;
            if (w_scl[c] > SAT_HI) begin
                w_val[c]  = SAT_HI[CW-1:0];
                w_clip[c] = 1'b1;
            end else if (w_scl[c] < SAT_LO) begin
                w_val[c]  = SAT_LO[CW-1:0];
                w_clip[c] = 1'b1;
            end else begin
                w_val[c]  = w_scl[c][CW-1:0];
                w_clip[c] = 1'b0;
            end
        end
        n_out.out_x     = w_val[0];
        n_out.out_y     = w_val[1];
        n_out.out_z     = w_val[2];
        n_out.saturated = |w_clip;
    end

    // Advance the payload of each stage that loads
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_p1 <= n_p1;
        end
        if (w_rdy[1]) begin
            r_t <= n_t;
        end
        if (w_rdy[2]) begin
            r_p2 <= n_p2;
        end
        if (w_rdy[3]) begin
            r_r <= n_r;
        end
        if (w_rdy[4]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // Quaternion equals the identity rotation
    logic w_quat_ident;
    assign w_quat_ident = (w_quat.qx == '0) && (w_quat.qy == '0) && (w_quat.qz == '0)
                       && (w_quat.qw == QW_RESET);

`include "quaternion_vector_rotate_assert.svh"

    // Input may only stall when every stage is occupied
    `QVR_ASSERT(a_stall_only_full, o_in_stall |-> (&r_vld), "input stalled with a free stage")
    // An accepted beat lands in the first stage
    `QVR_ASSERT(a_accept_lands, (i_in_valid && !o_in_stall) |=> r_vld[0], "accepted beat lost")
    // Leaving reset, the quaternion is the identity
    `QVR_ASSERT(a_reset_identity, $rose(i_rst_n) |-> w_quat_ident, "no identity after reset")
    // The pipe is empty after every reset cycle
    `QVR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (r_vld == '0), "stage valid set after reset")

endmodule
